// ===== hdl/frg_pkg.sv =====
package frg_pkg;

  localparam int STEP_W = 4;

  typedef logic [STEP_W-1:0] step_t;

  // Microprogram addresses
  localparam step_t STEP_WAIT     = 4'd0;
  localparam step_t STEP_CHECK    = 4'd1;
  localparam step_t STEP_GCD      = 4'd2;
  localparam step_t STEP_GCD_FIN  = 4'd3;
  localparam step_t STEP_DIV_NUM  = 4'd4;
  localparam step_t STEP_NUM_DONE = 4'd5;
  localparam step_t STEP_DIV_DEN  = 4'd6;
  localparam step_t STEP_EMIT     = 4'd7;
  localparam step_t STEP_RETURN   = 4'd8;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_WAIT,
    OP_GCD_STEP,
    OP_GCD_FIN,
    OP_DIV_STEP,
    OP_NUM_DONE,
    OP_EMIT
  } op_t;

  typedef enum logic [2:0] {
    COND_NEVER,
    COND_ALWAYS,
    COND_NO_INPUT,
    COND_ZERO,
    COND_GCD_BUSY,
    COND_DIV_BUSY,
    COND_OUT_BUSY
  } cond_t;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    step_t target;
  } ucode_t;

  typedef struct packed {
    logic no_input;
    logic zero_operand;
    logic gcd_busy;
    logic div_busy;
    logic out_busy;
  } dp_status_t;

  // Control store: jump to target when the condition holds, else fall through
  function automatic ucode_t ucode_rom(input step_t step);
    ucode_t w;
    case (step)
      STEP_WAIT:     w = '{op: OP_WAIT,     cond: COND_NO_INPUT, target: STEP_WAIT};
      STEP_CHECK:    w = '{op: OP_NOP,      cond: COND_ZERO,     target: STEP_EMIT};
      STEP_GCD:      w = '{op: OP_GCD_STEP, cond: COND_GCD_BUSY, target: STEP_GCD};
      STEP_GCD_FIN:  w = '{op: OP_GCD_FIN,  cond: COND_NEVER,    target: STEP_WAIT};
      STEP_DIV_NUM:  w = '{op: OP_DIV_STEP, cond: COND_DIV_BUSY, target: STEP_DIV_NUM};
      STEP_NUM_DONE: w = '{op: OP_NUM_DONE, cond: COND_NEVER,    target: STEP_WAIT};
      STEP_DIV_DEN:  w = '{op: OP_DIV_STEP, cond: COND_DIV_BUSY, target: STEP_DIV_DEN};
      STEP_EMIT:     w = '{op: OP_EMIT,     cond: COND_OUT_BUSY, target: STEP_EMIT};
      STEP_RETURN:   w = '{op: OP_NOP,      cond: COND_ALWAYS,   target: STEP_WAIT};
      default:       w = '{op: OP_NOP,      cond: COND_ALWAYS,   target: STEP_WAIT};
    endcase
    return w;
  endfunction

endpackage

// ===== hdl/frg_sequencer.sv =====
module frg_sequencer import frg_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  dp_status_t stat,
  output ucode_t     ctl
);

  step_t pc_r, pc_nxt;
  logic  take;

  assign ctl = ucode_rom(pc_r);

  always_comb begin
    case (ctl.cond)
      COND_NEVER:    take = 1'b0;
      COND_ALWAYS:   take = 1'b1;
      COND_NO_INPUT: take = stat.no_input;
      COND_ZERO:     take = stat.zero_operand;
      COND_GCD_BUSY: take = stat.gcd_busy;
      COND_DIV_BUSY: take = stat.div_busy;
      COND_OUT_BUSY: take = stat.out_busy;
      default:       take = 1'b1;
    endcase
  end

  always_comb begin
    pc_nxt = take ? ctl.target : step_t'(pc_r + 1'b1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= STEP_WAIT;
    end else begin
      pc_r <= pc_nxt;
    end
  end

  // a word taken at the wait step always moves on to the zero check
  a_accept_to_check: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.op == OP_WAIT && !stat.no_input) |=> (pc_r == STEP_CHECK))
    else $error("accepted word did not advance to zero check");

  // the control store never leaves the programme
  a_pc_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    pc_r <= STEP_RETURN)
    else $error("step counter outside microprogramme");

endmodule

// ===== hdl/frg_datapath.sv =====
module frg_datapath import frg_pkg::*; #(
  parameter int VALUE_WIDTH = 31
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  ucode_t                 ctl,
  output dp_status_t             stat,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [VALUE_WIDTH-1:0] in_numerator,
  input  logic [VALUE_WIDTH-1:0] in_denominator,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [VALUE_WIDTH-1:0] out_common_divisor,
  output logic [VALUE_WIDTH-1:0] out_reduced_numerator,
  output logic [VALUE_WIDTH-1:0] out_reduced_denominator,
  output logic                   out_zero_operand
);

  localparam int W  = VALUE_WIDTH;
  localparam int CW = $clog2(VALUE_WIDTH);
  localparam logic [CW-1:0] CNT_LAST = CW'(VALUE_WIDTH - 1);

  logic [W-1:0]  a_r, a_nxt, b_r, b_nxt;
  logic [W-1:0]  num_r, num_nxt, den_r, den_nxt;
  logic [W-1:0]  g_r, g_nxt, rem_r, rem_nxt, dv_r, dv_nxt, qn_r, qn_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          zero_r, zero_nxt;

  logic          out_valid_r, out_valid_nxt;
  logic [W-1:0]  out_g_r, out_g_nxt, out_n_r, out_n_nxt, out_d_r, out_d_nxt;
  logic          out_z_r, out_z_nxt;

  logic [W:0]    a_minus_b, b_minus_a;
  logic [W:0]    shifted;
  logic [W+1:0]  trial;
  logic          both_nz, out_free;

  assign in_ready  = (ctl.op == OP_WAIT);
  assign both_nz   = (a_r != '0) && (b_r != '0);
  assign out_free  = !out_valid_r || out_ready;
  assign a_minus_b = {1'b0, a_r} - {1'b0, b_r};
  assign b_minus_a = {1'b0, b_r} - {1'b0, a_r};
  assign shifted   = {rem_r, dv_r[W-1]};
  assign trial     = {1'b0, shifted} - {2'b00, g_r};

  always_comb begin
    stat.no_input     = !in_valid;
    stat.zero_operand = zero_r;
    stat.gcd_busy     = both_nz;
    stat.div_busy     = (cnt_r != CNT_LAST);
    stat.out_busy     = !out_free;
  end

  always_comb begin
    a_nxt         = a_r;
    b_nxt         = b_r;
    num_nxt       = num_r;
    den_nxt       = den_r;
    g_nxt         = g_r;
    rem_nxt       = rem_r;
    dv_nxt        = dv_r;
    qn_nxt        = qn_r;
    cnt_nxt       = cnt_r;
    zero_nxt      = zero_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_g_nxt     = out_g_r;
    out_n_nxt     = out_n_r;
    out_d_nxt     = out_d_r;
    out_z_nxt     = out_z_r;
    case (ctl.op)
      OP_WAIT: begin
        if (in_valid) begin
          a_nxt    = in_numerator;
          b_nxt    = in_denominator;
          num_nxt  = in_numerator;
          den_nxt  = in_denominator;
          zero_nxt = (in_numerator == '0) || (in_denominator == '0);
          cnt_nxt  = '0;
        end
      end
      OP_GCD_STEP: begin
        // binary gcd: strip shared twos, then odd twos, then subtract
        if (both_nz) begin
          if (!a_r[0] && !b_r[0]) begin
            a_nxt   = a_r >> 1;
            b_nxt   = b_r >> 1;
            cnt_nxt = cnt_r + 1'b1;
          end else if (!a_r[0]) begin
            a_nxt = a_r >> 1;
          end else if (!b_r[0]) begin
            b_nxt = b_r >> 1;
          end else if (!a_minus_b[W]) begin
            a_nxt = a_minus_b[W-1:0];
          end else begin
            b_nxt = b_minus_a[W-1:0];
          end
        end
      end
      OP_GCD_FIN: begin
        g_nxt   = (a_r | b_r) << cnt_r;
        dv_nxt  = num_r;
        rem_nxt = '0;
        cnt_nxt = '0;
      end
      OP_DIV_STEP: begin
        // restoring division, one quotient bit per step
        if (!trial[W+1]) begin
          rem_nxt = trial[W-1:0];
        end else begin
          rem_nxt = shifted[W-1:0];
        end
        dv_nxt  = {dv_r[W-2:0], !trial[W+1]};
        cnt_nxt = cnt_r + 1'b1;
      end
      OP_NUM_DONE: begin
        qn_nxt  = dv_r;
        dv_nxt  = den_r;
        rem_nxt = '0;
        cnt_nxt = '0;
      end
      OP_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_z_nxt     = zero_r;
          out_g_nxt     = zero_r ? '0 : g_r;
          out_n_nxt     = zero_r ? '0 : qn_r;
          out_d_nxt     = zero_r ? '0 : dv_r;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_r     <= a_nxt;
    b_r     <= b_nxt;
    num_r   <= num_nxt;
    den_r   <= den_nxt;
    g_r     <= g_nxt;
    rem_r   <= rem_nxt;
    dv_r    <= dv_nxt;
    qn_r    <= qn_nxt;
    cnt_r   <= cnt_nxt;
    zero_r  <= zero_nxt;
    out_g_r <= out_g_nxt;
    out_n_r <= out_n_nxt;
    out_d_r <= out_d_nxt;
    out_z_r <= out_z_nxt;
  end

  assign out_valid               = out_valid_r;
  assign out_common_divisor      = out_g_r;
  assign out_reduced_numerator   = out_n_r;
  assign out_reduced_denominator = out_d_r;
  assign out_zero_operand        = out_z_r;

  a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.op == OP_DIV_STEP) |-> (g_r != '0))
    else $error("division started with zero divisor");

  a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_z_r) |-> (out_g_r == '0 && out_n_r == '0 && out_d_r == '0))
    else $error("error word carries non-zero values");

  a_gcd_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_z_r) |-> (out_g_r != '0))
    else $error("valid word with zero divisor");

endmodule

// ===== hdl/fraction_reducer_gcd.sv =====
// Channel  Handshake                Payload
// in       in_valid / in_ready      in_numerator, in_denominator
// out      out_valid / out_ready    out_common_divisor, out_reduced_numerator,
//                                   out_reduced_denominator, out_zero_operand
//
// One word at a time. The GCD loop takes one step per halving or subtraction;
// the two restoring divisions that follow, numerator first, each yield a
// VALUE_WIDTH-bit quotient. A zero operand skips straight to the result.
// Reset clears the step counter and the result valid flag only.
// A stalled result holds in the output register; the next word is taken
// while it waits, and its result waits at the emit step until the slot frees.
module fraction_reducer_gcd import frg_pkg::*; #(
  parameter int VALUE_WIDTH = 31
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [VALUE_WIDTH-1:0] in_numerator,
  input  logic [VALUE_WIDTH-1:0] in_denominator,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [VALUE_WIDTH-1:0] out_common_divisor,
  output logic [VALUE_WIDTH-1:0] out_reduced_numerator,
  output logic [VALUE_WIDTH-1:0] out_reduced_denominator,
  output logic                   out_zero_operand
);

  ucode_t     ctl;
  dp_status_t stat;

  frg_sequencer u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .stat  (stat),
    .ctl   (ctl)
  );

  frg_datapath #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_dp (
    .clk                     (clk),
    .rst_n                   (rst_n),
    .ctl                     (ctl),
    .stat                    (stat),
    .in_valid                (in_valid),
    .in_ready                (in_ready),
    .in_numerator            (in_numerator),
    .in_denominator          (in_denominator),
    .out_valid               (out_valid),
    .out_ready               (out_ready),
    .out_common_divisor      (out_common_divisor),
    .out_reduced_numerator   (out_reduced_numerator),
    .out_reduced_denominator (out_reduced_denominator),
    .out_zero_operand        (out_zero_operand)
  );

endmodule
